### hdl/pbpm_pkg.sv
// Shared constants, request codes, command/status structs and metadata record
// for the packet buffer pool manager. No dependencies.
`default_nettype none

package pbpm_pkg;

    localparam int NUM_BLOCKS   = 256;
    localparam int BLOCK_BYTES  = 2048;
    localparam int FILLED_DEPTH = 256;

    localparam int FREE_AW   = $clog2(NUM_BLOCKS);
    localparam int FREE_CW   = $clog2(NUM_BLOCKS + 1);
    localparam int FILL_AW   = $clog2(FILLED_DEPTH);
    localparam int FILL_CW   = $clog2(FILLED_DEPTH + 1);
    localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);

    localparam int REQ_W    = 2;
    localparam int HANDLE_W = 8;
    localparam int LEN_IN_W = 16;
    localparam int TS_W     = 64;
    localparam int IFACE_W  = 16;
    localparam int KIND_W   = 8;
    localparam int LEN_W    = 12;
    localparam int ADDR_W   = 19;
    localparam int CNT_W    = 32;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 192;
    localparam int M_PAD_W   = M_TDATA_W - (HANDLE_W + ADDR_W + LEN_W + TS_W + IFACE_W
                                            + KIND_W + 2 * CNT_W);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_COMMIT  = 2'd1,
        REQ_POP     = 2'd2,
        REQ_RELEASE = 2'd3
    } req_t;

    typedef struct packed {
        logic accept;   // input transfer, capture request
        logic exec;     // decide, update pointers and counters, issue reads
        logic fetch;    // FIFO read data back, issue metadata read
        logic load;     // write the output register
    } pbpm_cmd_t;

    typedef struct packed {
        logic out_busy; // output register holds a transfer not yet taken
    } pbpm_sts_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [TS_W-1:0]    ts;
        logic [IFACE_W-1:0] iface;
        logic [KIND_W-1:0]  kind;
    } meta_t;

    function automatic logic handle_in_range(input logic [HANDLE_W-1:0] h);
        return 32'(h) < NUM_BLOCKS;
    endfunction

endpackage

`default_nettype wire

### hdl/packet_buffer_pool_manager.sv
// Packet buffer pool manager: one request in, one result out per request.
// Each request walks EXEC, FETCH, META and LOAD in the sequencer, which reads
// the FIFO and then the dependent metadata, both with registered read data.
// LOAD registers the result, waiting while the output is busy; then ready rises.
// Reset (rst_n, async, active low): free list full (handles in order), filled
// list empty, drop counters zero; no clearing pass, ready right after reset.
`default_nettype none

module packet_buffer_pool_manager import pbpm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // handle[7:0], length[23:8], timestamp_us[87:24], iface_index[103:88],
    // packet_kind[111:104]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [REQ_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // grant_handle[7:0], block_addr[26:8], out_length[38:27],
    // out_timestamp[102:39], out_iface[118:103], out_kind[126:119],
    // no_free_drops[158:127], ring_full_drops[190:159], zero pad[191]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // ok[0]
    output logic                      m_tuser
);

    pbpm_cmd_t cmd;
    pbpm_sts_t sts;

    pbpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbpm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    logic [HANDLE_W-1:0] chk_handle;
    logic [ADDR_W-1:0]   chk_addr;

    assign chk_handle = m_tdata[HANDLE_W-1:0];
    assign chk_addr   = m_tdata[HANDLE_W +: ADDR_W];

`ifndef ASSERT_OFF
    // one request in flight: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request was in flight");

    // block address always follows the handle
    a_addr_of_handle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chk_addr == (ADDR_W'(chk_handle) << BLK_SHIFT))
        else $error("block address does not match handle");

    // a failed request carries no handle
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> chk_handle == '0 && chk_addr == '0)
        else $error("failed request returned a handle");
`endif

endmodule

`default_nettype wire

### hdl/pbpm_ctrl.sv
// Request sequencer for the packet buffer pool manager.
// Depends on pbpm_pkg; drives the command struct of pbpm_dp.
`default_nettype none

module pbpm_ctrl import pbpm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire pbpm_sts_t sts,
    output pbpm_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_META,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    state_next = ST_EXEC;
                    ready_next = 1'b0;
                end
            end
            ST_EXEC:  state_next = ST_FETCH;
            ST_FETCH: state_next = ST_META;
            ST_META:  state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready   = ready_reg;
    assign cmd.accept = s_tvalid && ready_reg;
    assign cmd.exec   = (state_reg == ST_EXEC);
    assign cmd.fetch  = (state_reg == ST_FETCH);
    assign cmd.load   = (state_reg == ST_LOAD) && !sts.out_busy;

endmodule

`default_nettype wire

### hdl/pbpm_dp.sv
// Datapath of the packet buffer pool manager: free and filled handle FIFOs,
// metadata store, drop counters and output register. Depends on pbpm_pkg.
`default_nettype none

module pbpm_dp import pbpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pbpm_cmd_t             cmd,
    output pbpm_sts_t                  sts,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [REQ_W-1:0]      s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser
);

    // input fields
    logic [HANDLE_W-1:0] in_handle;
    logic [LEN_IN_W-1:0] in_len;
    logic [TS_W-1:0]     in_ts;
    logic [IFACE_W-1:0]  in_iface;
    logic [KIND_W-1:0]   in_kind;

    assign {in_kind, in_iface, in_ts, in_len, in_handle} = s_tdata;

    // captured request (payload)
    req_t                req_reg;
    logic [HANDLE_W-1:0] handle_reg;
    meta_t               meta_in_reg;

    // memories
    logic [FREE_AW-1:0] free_mem [NUM_BLOCKS];
    logic [FREE_AW-1:0] fill_mem [FILLED_DEPTH];
    meta_t              meta_mem [NUM_BLOCKS];
    logic [FREE_AW-1:0] free_q;
    logic [FREE_AW-1:0] fill_q;
    meta_t              meta_q;

    // control state
    logic [FREE_AW-1:0] free_rd_reg, free_rd_next;
    logic [FREE_AW-1:0] free_wr_reg, free_wr_next;
    logic               free_wrap_reg, free_wrap_next;
    logic [FREE_CW-1:0] free_cnt_reg, free_cnt_next;
    logic [FILL_AW-1:0] fill_rd_reg, fill_rd_next;
    logic [FILL_AW-1:0] fill_wr_reg, fill_wr_next;
    logic [FILL_CW-1:0] fill_cnt_reg, fill_cnt_next;
    logic [CNT_W-1:0]   nofree_reg, nofree_next;
    logic [CNT_W-1:0]   ringfull_reg, ringfull_next;
    logic               ok_reg, ok_next;

    // read-side payload
    logic               free_fresh_reg;
    logic [FREE_AW-1:0] free_idx_reg;
    logic [FREE_AW-1:0] hnd_reg;

    // output register
    logic                 m_valid_reg;
    logic                 m_ok_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic free_push, free_pop, fill_push, fill_pop, meta_we;
    logic free_full, fill_full;

    assign free_full = (free_cnt_reg == FREE_CW'(NUM_BLOCKS));
    assign fill_full = (fill_cnt_reg == FILL_CW'(FILLED_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg         <= req_t'(s_tuser);
            handle_reg      <= in_handle;
            meta_in_reg.len <= (32'(in_len) > BLOCK_BYTES) ? LEN_W'(BLOCK_BYTES)
                                                            : LEN_W'(in_len);
            meta_in_reg.ts    <= in_ts;
            meta_in_reg.iface <= in_iface;
            meta_in_reg.kind  <= in_kind;
        end
    end

    always_comb
    begin
        free_push     = 1'b0;
        free_pop      = 1'b0;
        fill_push     = 1'b0;
        fill_pop      = 1'b0;
        meta_we       = 1'b0;
        ok_next       = 1'b0;
        nofree_next   = nofree_reg;
        ringfull_next = ringfull_reg;
        if (cmd.exec)
        begin
            case (req_reg)
                REQ_ALLOC:
                begin
                    if (free_cnt_reg == '0)
                        nofree_next = nofree_reg + 1'b1;
                    else
                    begin
                        free_pop = 1'b1;
                        ok_next  = 1'b1;
                    end
                end
                REQ_COMMIT:
                begin
                    if (handle_in_range(handle_reg))
                    begin
                        meta_we = 1'b1;
                        if (fill_full)
                        begin
                            // ring full: handle goes back to the free list if that has room
                            ringfull_next = ringfull_reg + 1'b1;
                            free_push     = !free_full;
                        end
                        else
                        begin
                            fill_push = 1'b1;
                            ok_next   = 1'b1;
                        end
                    end
                end
                REQ_POP:
                begin
                    if (fill_cnt_reg != '0)
                    begin
                        fill_pop = 1'b1;
                        ok_next  = 1'b1;
                    end
                end
                REQ_RELEASE:
                begin
                    if (handle_in_range(handle_reg) && !free_full)
                    begin
                        free_push = 1'b1;
                        ok_next   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        free_rd_next   = free_rd_reg;
        free_wr_next   = free_wr_reg;
        free_wrap_next = free_wrap_reg;
        free_cnt_next  = free_cnt_reg;
        fill_rd_next   = fill_rd_reg;
        fill_wr_next   = fill_wr_reg;
        fill_cnt_next  = fill_cnt_reg;
        if (free_pop)
        begin
            free_rd_next  = (32'(free_rd_reg) == NUM_BLOCKS - 1) ? '0 : free_rd_reg + 1'b1;
            free_cnt_next = free_cnt_reg - 1'b1;
        end
        if (free_push)
        begin
            if (32'(free_wr_reg) == NUM_BLOCKS - 1)
            begin
                free_wr_next   = '0;
                free_wrap_next = 1'b1;
            end
            else
                free_wr_next = free_wr_reg + 1'b1;
            free_cnt_next = free_cnt_reg + 1'b1;
        end
        if (fill_pop)
        begin
            fill_rd_next  = (32'(fill_rd_reg) == FILLED_DEPTH - 1) ? '0 : fill_rd_reg + 1'b1;
            fill_cnt_next = fill_cnt_reg - 1'b1;
        end
        if (fill_push)
        begin
            fill_wr_next  = (32'(fill_wr_reg) == FILLED_DEPTH - 1) ? '0 : fill_wr_reg + 1'b1;
            fill_cnt_next = fill_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_rd_reg   <= '0;
            free_wr_reg   <= '0;
            free_wrap_reg <= 1'b0;
            free_cnt_reg  <= FREE_CW'(NUM_BLOCKS);
            fill_rd_reg   <= '0;
            fill_wr_reg   <= '0;
            fill_cnt_reg  <= '0;
            nofree_reg    <= '0;
            ringfull_reg  <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            free_rd_reg   <= free_rd_next;
            free_wr_reg   <= free_wr_next;
            free_wrap_reg <= free_wrap_next;
            free_cnt_reg  <= free_cnt_next;
            fill_rd_reg   <= fill_rd_next;
            fill_wr_reg   <= fill_wr_next;
            fill_cnt_reg  <= fill_cnt_next;
            nofree_reg    <= nofree_next;
            ringfull_reg  <= ringfull_next;
            if (cmd.exec)
                ok_reg <= ok_next;
        end
    end

    // Free list starts as 0..N-1; entries not yet written since reset read as
    // their own index. Writes go in ring order, so the write pointer and a
    // wrap flag tell which entries have been written.
    always_ff @(posedge clk)
    begin
        if (free_push)
            free_mem[free_wr_reg] <= FREE_AW'(handle_reg);
        free_q <= free_mem[free_rd_reg];
        if (cmd.exec)
        begin
            free_fresh_reg <= !(free_wrap_reg || (free_rd_reg < free_wr_reg));
            free_idx_reg   <= free_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_push)
            fill_mem[fill_wr_reg] <= FREE_AW'(handle_reg);
        fill_q <= fill_mem[fill_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[FREE_AW'(handle_reg)] <= meta_in_reg;
        meta_q <= meta_mem[hnd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            if (req_reg == REQ_ALLOC)
                hnd_reg <= free_fresh_reg ? free_idx_reg : free_q;
            else
                hnd_reg <= fill_q;
        end
    end

    logic                is_alloc_ok, is_pop_ok;
    logic [HANDLE_W-1:0] o_handle;
    logic [ADDR_W-1:0]   o_addr;
    meta_t               o_meta;

    assign is_alloc_ok = ok_reg && (req_reg == REQ_ALLOC);
    assign is_pop_ok   = ok_reg && (req_reg == REQ_POP);
    assign o_handle    = (is_alloc_ok || is_pop_ok) ? HANDLE_W'(hnd_reg) : '0;
    assign o_addr      = ADDR_W'(o_handle) << BLK_SHIFT;
    assign o_meta      = is_pop_ok ? meta_q : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_ok_reg   <= ok_reg;
            m_data_reg <= {{M_PAD_W{1'b0}}, ringfull_reg, nofree_reg, o_meta.kind,
                           o_meta.iface, o_meta.ts, o_meta.len, o_addr, o_handle};
        end
    end

    assign sts.out_busy = m_valid_reg && !m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;
    assign m_tuser      = m_ok_reg;

endmodule

`default_nettype wire
